>>> rtl/fcpi_pkg.sv
// shared types, widths and helpers for the fan curve pwm interpolator
package fcpi_pkg;

  // sample and arithmetic widths
  localparam int TEMP_W     = 18;  // signed millidegree sample
  localparam int DEN_W      = 19;  // signed segment span in millidegrees
  localparam int DT_W       = 20;  // signed offset of sample from lower breakpoint
  localparam int NUM_W      = 30;  // signed interpolation numerator
  localparam int MAG_W      = NUM_W - 1;
  localparam int DEN_MAG_W  = DEN_W - 1;
  localparam int APB_ADDR_W = 4;

  localparam logic [TEMP_W-1:0] MILLI_PER_DEG = TEMP_W'(1000);
  localparam logic [MAG_W-1:0]  PCT_FULL      = MAG_W'(100);
  localparam logic [7:0]        DUTY_FULL     = 8'd255;
  // 255/100 as a fixed-point reciprocal, exact for percents below 100
  localparam logic [20:0]       DUTY_RECIP    = 21'd1336965;
  localparam int                DUTY_SHIFT    = 19;

  typedef struct packed {
    logic [31:0] temps;
    logic [31:0] pcts;
    logic [2:0]  count;
  } cfg_t;

  typedef struct packed {
    logic                    above;
    logic                    flat;
    logic [7:0]              p1;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } seg_res_t;

  // whole degrees to millidegrees
  function automatic logic [TEMP_W-1:0] milli_of(input logic [7:0] deg);
    return TEMP_W'({{(TEMP_W-8){1'b0}}, deg}) * MILLI_PER_DEG;
  endfunction

  // percent to duty: trunc(pct*255/100), clamped to 0..255
  function automatic logic [7:0] pct_to_duty(input logic neg, input logic [MAG_W-1:0] mag);
    logic [27:0] prod;
    logic [7:0]  res;
    prod = 28'(mag[6:0]) * 28'(DUTY_RECIP);
    if (neg || mag == '0) begin
      res = '0;
    end else if (mag >= PCT_FULL) begin
      res = DUTY_FULL;
    end else begin
      res = prod[DUTY_SHIFT +: 8];
    end
    return res;
  endfunction

endpackage

>>> rtl/fcpi_chan_if.sv
// valid/ready channel interfaces for temperature samples and duty results
interface fcpi_temp_if;
  import fcpi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temp_milli;
  modport source (output valid, output temp_milli, input ready);
  modport sink   (input valid, input temp_milli, output ready);
endinterface

interface fcpi_duty_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty;
  logic       write_duty;
  logic       above_curve;
  modport source (output valid, output duty, output write_duty, output above_curve, input ready);
  modport sink   (input valid, input duty, input write_duty, input above_curve, output ready);
endinterface

>>> rtl/fan_curve_pwm_interpolator.sv
// top level: fan curve interpolation from temperature sample to pwm duty
// One temperature transaction in gives one duty transaction out. The block
// handles one sample at a time: the sample is taken only when the block is
// idle, while an earlier result may still sit in the output register. A sample
// passes through the segment search, which scans one curve segment at a time,
// then the bit-serial divider, a scaling step and the output register. Samples
// on a flat segment skip the divider, and samples above the curve also skip the
// scaling step. Curve registers sit on the apb port at byte addresses 0,
// 4 and 8 and are meant to be written only while no sample is in flight.
module fan_curve_pwm_interpolator #(
  parameter int NUM_POINTS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  fcpi_temp_if.sink                       sample_i,
  fcpi_duty_if.source                     duty_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fcpi_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import fcpi_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SEARCH = 5'b00010,
    ST_DIVIDE = 5'b00100,
    ST_SCALE  = 5'b01000,
    ST_EMIT   = 5'b10000
  } top_state_e;

  top_state_e       state_q, state_d;
  cfg_t             cfg;
  seg_res_t         seg_res;
  logic             seg_done, seg_start;
  logic             div_start, div_done, div_neg;
  logic [MAG_W-1:0] div_quo;
  logic             above_q, pct_neg_q;
  logic [MAG_W-1:0] pct_mag_q;
  logic [7:0]       duty_q, last_duty_q;
  logic             out_valid_q, out_write_q, out_above_q;
  logic [7:0]       out_duty_q;
  logic             out_load, out_write;

  fcpi_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fcpi_seg #(
    .NUM_POINTS (NUM_POINTS)
  ) u_seg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (seg_start),
    .temp_i  (sample_i.temp_milli),
    .cfg_i   (cfg),
    .done_o  (seg_done),
    .res_o   (seg_res)
  );

  fcpi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (seg_res.num),
    .den_i   (seg_res.den),
    .done_o  (div_done),
    .neg_o   (div_neg),
    .quo_o   (div_quo)
  );

  assign sample_i.ready = (state_q == ST_IDLE);
  assign seg_start      = sample_i.valid && sample_i.ready;
  assign div_start      = (state_q == ST_SEARCH) && seg_done && !seg_res.above
                          && !seg_res.flat;
  assign out_load       = (state_q == ST_EMIT) && (!out_valid_q || duty_o.ready);
  assign out_write      = !above_q && (duty_q != last_duty_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (seg_start) state_d = ST_SEARCH;
      ST_SEARCH: begin
        if (seg_done) begin
          if (seg_res.above) begin
            state_d = ST_EMIT;
          end else if (seg_res.flat) begin
            state_d = ST_SCALE;
          end else begin
            state_d = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: if (div_done) state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_EMIT;
      ST_EMIT:   if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_duty_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
        if (out_write) last_duty_q <= duty_q;
      end else if (duty_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SEARCH && seg_done) begin
      above_q   <= seg_res.above;
      pct_neg_q <= 1'b0;
      pct_mag_q <= MAG_W'(seg_res.p1);
      // above the curve the held duty goes out unchanged
      duty_q    <= last_duty_q;
    end else if (state_q == ST_DIVIDE && div_done) begin
      pct_neg_q <= div_neg;
      pct_mag_q <= div_quo;
    end else if (state_q == ST_SCALE) begin
      duty_q <= pct_to_duty(pct_neg_q, pct_mag_q);
    end
    if (out_load) begin
      out_duty_q  <= duty_q;
      out_write_q <= out_write;
      out_above_q <= above_q;
    end
  end

  assign duty_o.valid       = out_valid_q;
  assign duty_o.duty        = out_duty_q;
  assign duty_o.write_duty  = out_write_q;
  assign duty_o.above_curve = out_above_q;

  a_held_duty_is_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_o.valid && (duty_o.write_duty || duty_o.above_curve) |-> duty_o.duty == last_duty_q)
    else $error("written or held duty differs from last duty");

  a_seg_done_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_done |-> state_q == ST_SEARCH)
    else $error("segment result arrived outside search");

endmodule

>>> rtl/fcpi_regs.sv
// apb configuration registers: breakpoint temperatures, percents and point count
module fcpi_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fcpi_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output fcpi_pkg::cfg_t                  cfg_o
);
  import fcpi_pkg::*;

  typedef enum logic [1:0] {
    REG_TEMPS = 2'd0,
    REG_PCTS  = 2'd1,
    REG_COUNT = 2'd2
  } reg_idx_e;

  reg_idx_e    idx;
  logic        wr_en;
  logic [31:0] temps_q, pcts_q;
  logic [2:0]  count_q;

  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temps_q <= '0;
      pcts_q  <= '0;
      count_q <= 3'd2;
    end else if (wr_en) begin
      case (idx)
        REG_TEMPS: temps_q <= pwdata;
        REG_PCTS:  pcts_q  <= pwdata;
        REG_COUNT: count_q <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TEMPS: prdata = temps_q;
      REG_PCTS:  prdata = pcts_q;
      REG_COUNT: prdata = {29'd0, count_q};
      default:   prdata = '0;
    endcase
  end

  assign cfg_o = '{temps: temps_q, pcts: pcts_q, count: count_q};

endmodule

>>> rtl/fcpi_seg.sv
// segment search over byte shift registers and interpolation numerator setup
module fcpi_seg #(
  parameter int NUM_POINTS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [fcpi_pkg::TEMP_W-1:0] temp_i,
  input  fcpi_pkg::cfg_t                  cfg_i,
  output logic                            done_o,
  output fcpi_pkg::seg_res_t              res_o
);
  import fcpi_pkg::*;

  localparam int SegW = $clog2(NUM_POINTS);

  typedef enum logic [2:0] {
    SEG_IDLE = 3'b001,
    SEG_SCAN = 3'b010,
    SEG_CALC = 3'b100
  } seg_state_e;

  seg_state_e               state_q, state_d;
  logic [7:0]               tsrc [NUM_POINTS];
  logic [7:0]               psrc [NUM_POINTS];
  logic [7:0]               tb_q [NUM_POINTS];
  logic [7:0]               pb_q [NUM_POINTS];
  logic [SegW-1:0]          left_q, segs;
  logic [3:0]               cnt_ext;
  logic signed [TEMP_W-1:0] temp_q;
  logic [TEMP_W-1:0]        t0m_q, t1m_q, t1m;
  logic [7:0]               p0_q, p1_q;
  logic                     hit, last_seg;
  logic                     done_q;
  seg_res_t                 res_q;

  // breakpoints past the four packed bytes read as zero
  for (genvar k = 0; k < NUM_POINTS; k++) begin : g_src
    if (k < 4) begin : g_cfg
      assign tsrc[k] = cfg_i.temps[8*k +: 8];
      assign psrc[k] = cfg_i.pcts[8*k +: 8];
    end else begin : g_zero
      assign tsrc[k] = '0;
      assign psrc[k] = '0;
    end
  end

  assign cnt_ext = {1'b0, cfg_i.count};

  always_comb begin
    if (cnt_ext < 4'd2) begin
      segs = SegW'(1);
    end else if (cnt_ext > 4'(NUM_POINTS)) begin
      segs = SegW'(NUM_POINTS - 1);
    end else begin
      segs = SegW'(cnt_ext - 4'd1);
    end
  end

  assign t1m      = milli_of(tb_q[1]);
  assign hit      = $signed({temp_q[TEMP_W-1], temp_q}) <= $signed({1'b0, t1m});
  assign last_seg = (left_q == SegW'(1));

  // numerator p0*d + (p1-p0)*(t-t0) over the span d
  logic signed [DEN_W-1:0] span;
  logic signed [DT_W-1:0]  dt;
  logic signed [8:0]       p0s, dp;
  logic signed [NUM_W-1:0] prod_a, prod_b;

  always_comb begin
    span   = $signed({1'b0, t1m_q}) - $signed({1'b0, t0m_q});
    dt     = $signed({{(DT_W-TEMP_W){temp_q[TEMP_W-1]}}, temp_q})
           - $signed({{(DT_W-TEMP_W){1'b0}}, t0m_q});
    p0s    = $signed({1'b0, p0_q});
    dp     = $signed({1'b0, p1_q}) - p0s;
    prod_a = NUM_W'(p0s) * NUM_W'(span);
    prod_b = NUM_W'(dp) * NUM_W'(dt);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SEG_IDLE: if (start_i) state_d = SEG_SCAN;
      SEG_SCAN: begin
        if (hit) begin
          state_d = SEG_CALC;
        end else if (last_seg) begin
          state_d = SEG_IDLE;
        end
      end
      SEG_CALC: state_d = SEG_IDLE;
      default:  state_d = SEG_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEG_IDLE;
      done_q  <= 1'b0;
      left_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == SEG_CALC) || (state_q == SEG_SCAN && !hit && last_seg);
      if (state_q == SEG_IDLE && start_i) begin
        left_q <= segs;
      end else if (state_q == SEG_SCAN && !hit) begin
        left_q <= left_q - SegW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SEG_IDLE && start_i) begin
      temp_q <= temp_i;
      for (int k = 0; k < NUM_POINTS; k++) begin
        tb_q[k] <= tsrc[k];
        pb_q[k] <= psrc[k];
      end
    end else if (state_q == SEG_SCAN) begin
      // step to the next segment one byte at a time
      for (int k = 0; k < NUM_POINTS - 1; k++) begin
        tb_q[k] <= tb_q[k+1];
        pb_q[k] <= pb_q[k+1];
      end
      tb_q[NUM_POINTS-1] <= '0;
      pb_q[NUM_POINTS-1] <= '0;
      if (hit) begin
        t0m_q <= milli_of(tb_q[0]);
        t1m_q <= t1m;
        p0_q  <= pb_q[0];
        p1_q  <= pb_q[1];
      end else if (last_seg) begin
        res_q.above <= 1'b1;
        res_q.flat  <= 1'b0;
      end
    end else if (state_q == SEG_CALC) begin
      res_q.above <= 1'b0;
      res_q.flat  <= (t1m_q == t0m_q);
      res_q.p1    <= p1_q;
      res_q.num   <= prod_a + prod_b;
      res_q.den   <= span;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == SEG_IDLE)
    else $error("segment search started while busy");

endmodule

>>> rtl/fcpi_div.sv
// bit-serial restoring divider, one quotient bit per cycle, truncating toward zero
module fcpi_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [fcpi_pkg::NUM_W-1:0]    num_i,
  input  logic signed [fcpi_pkg::DEN_W-1:0]    den_i,
  output logic                                 done_o,
  output logic                                 neg_o,
  output logic [fcpi_pkg::MAG_W-1:0]           quo_o
);
  import fcpi_pkg::*;

  localparam int CntW = $clog2(MAG_W + 1);

  logic                   busy_q, done_q, neg_q;
  logic [CntW-1:0]        cnt_q;
  logic [MAG_W-1:0]       quo_q, num_mag;
  logic [DEN_MAG_W-1:0]   rem_q, den_q, den_mag;
  logic [DEN_MAG_W:0]     rem_sh;
  logic [DEN_MAG_W+1:0]   diff;
  logic                   take;

  assign num_mag = num_i[NUM_W-1] ? MAG_W'(-num_i) : num_i[MAG_W-1:0];
  assign den_mag = den_i[DEN_W-1] ? DEN_MAG_W'(-den_i) : den_i[DEN_MAG_W-1:0];

  // next dividend bit enters the partial remainder from the quotient register
  assign rem_sh = {rem_q, quo_q[MAG_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
  assign take   = !diff[DEN_MAG_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(MAG_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_mag;
      rem_q <= '0;
      den_q <= den_mag;
      neg_q <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
    end else if (busy_q) begin
      quo_q <= {quo_q[MAG_W-2:0], take};
      rem_q <= take ? diff[DEN_MAG_W-1:0] : rem_sh[DEN_MAG_W-1:0];
    end
  end

  assign done_o = done_q;
  assign neg_o  = neg_q;
  assign quo_o  = quo_q;

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < den_q)
    else $error("partial remainder not below divisor");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> den_i != '0 && !busy_q)
    else $error("divide started with zero divisor or while busy");

endmodule

>>> dv/fcpi_tb_pkg.sv
`timescale 1ns / 100ps
// register map and duty result type shared by the testbench files
package fcpi_tb_pkg;
  import fcpi_pkg::*;

  localparam logic [APB_ADDR_W-1:0] CURVE_TEMPS_ADDR = APB_ADDR_W'(4'h0);
  localparam logic [APB_ADDR_W-1:0] CURVE_PCTS_ADDR  = APB_ADDR_W'(4'h4);
  localparam logic [APB_ADDR_W-1:0] POINT_COUNT_ADDR = APB_ADDR_W'(4'h8);

  typedef struct packed {
    logic [7:0] duty;
    logic       write_duty;
    logic       above_curve;
  } duty_res_t;

endpackage

>>> dv/fcpi_duty_check.sv
`timescale 1ns / 100ps
// checker: follows curve writes, predicts every duty transaction and compares
module fcpi_duty_check #(
  parameter int NUM_POINTS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  fcpi_temp_if                            temp_w,
  fcpi_duty_if                            duty_w,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [fcpi_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output int                              fail_cnt_o,
  output int                              due_cnt_o,
  output int                              checked_cnt_o,
  output int                              above_cnt_o,
  output int                              writes_cnt_o
);
  import fcpi_pkg::*;
  import fcpi_tb_pkg::*;

  localparam longint DEG_TO_MILLI = 1000;
  localparam longint DUTY_MAX     = 255;
  localparam longint PCT_SCALE    = 100;
  localparam int     MAX_REPORTS  = 10;

  logic [31:0] temps_q;
  logic [31:0] pcts_q;
  logic [2:0]  count_q;
  logic [7:0]  held_duty;
  duty_res_t   due_duty_q[$];
  int          fails, checked, aboves, writes;

  // breakpoints past the four packed bytes read as zero
  function automatic longint curve_byte(input logic [31:0] word, input int idx);
    if (idx >= 4) return 0;
    return longint'(word[8*idx +: 8]);
  endfunction

  function automatic duty_res_t duty_for_sample(input logic signed [TEMP_W-1:0] sample);
    longint    t, lo_t, hi_t, lo_p, hi_p, span, num, pct, scaled;
    int        segs;
    bit        hit;
    duty_res_t res;
    t    = sample;
    segs = int'(count_q);
    if (segs < 2) segs = 2;
    if (segs > NUM_POINTS) segs = NUM_POINTS;
    // default is the above-curve answer: hold the duty, no write
    res.duty        = held_duty;
    res.write_duty  = 1'b0;
    res.above_curve = 1'b1;
    hit             = 1'b0;
    for (int i = 0; i + 1 < segs && !hit; i++) begin
      lo_t = curve_byte(temps_q, i) * DEG_TO_MILLI;
      hi_t = curve_byte(temps_q, i + 1) * DEG_TO_MILLI;
      lo_p = curve_byte(pcts_q, i);
      hi_p = curve_byte(pcts_q, i + 1);
      if (t <= hi_t) begin
        hit = 1'b1;
        if (hi_t == lo_t) begin
          pct = hi_p;
        end else begin
          span = hi_t - lo_t;
          num  = lo_p * span + (hi_p - lo_p) * (t - lo_t);
          if (span < 0) begin
            span = -span;
            num  = -num;
          end
          pct = num / span;
        end
        scaled = (pct * DUTY_MAX) / PCT_SCALE;
        if (scaled < 0) scaled = 0;
        if (scaled > DUTY_MAX) scaled = DUTY_MAX;
        res.duty        = 8'(scaled);
        res.above_curve = 1'b0;
        res.write_duty  = (res.duty != held_duty);
        held_duty       = res.duty;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    duty_res_t want, got;
    if (!rst_ni) begin
      temps_q   = '0;
      pcts_q    = '0;
      count_q   = 3'd2;
      held_duty = '0;
      due_duty_q.delete();
      fails   = 0;
      checked = 0;
      aboves  = 0;
      writes  = 0;
    end else begin
      // result side first: a sample taken at this edge cannot be answered yet
      if (duty_w.valid && duty_w.ready) begin
        got = '{duty: duty_w.duty, write_duty: duty_w.write_duty,
                above_curve: duty_w.above_curve};
        checked++;
        if (got.above_curve === 1'b1) aboves++;
        if (got.write_duty === 1'b1) writes++;
        if (due_duty_q.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: unexpected duty transaction duty=%0d write=%b above=%b",
                     $realtime, got.duty, got.write_duty, got.above_curve);
        end else begin
          want = due_duty_q.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= MAX_REPORTS)
              $display("%0t: duty mismatch exp duty=%0d write=%b above=%b, got duty=%0d write=%b above=%b",
                       $realtime, want.duty, want.write_duty, want.above_curve,
                       got.duty, got.write_duty, got.above_curve);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          CURVE_TEMPS_ADDR: temps_q = pwdata;
          CURVE_PCTS_ADDR:  pcts_q  = pwdata;
          POINT_COUNT_ADDR: count_q = pwdata[2:0];
          default: ;
        endcase
      end
      if (temp_w.valid && temp_w.ready)
        due_duty_q.insert(due_duty_q.size(), duty_for_sample(temp_w.temp_milli));
    end
    fail_cnt_o    <= fails;
    due_cnt_o     <= due_duty_q.size();
    checked_cnt_o <= checked;
    above_cnt_o   <= aboves;
    writes_cnt_o  <= writes;
  end

endmodule

>>> dv/tb_fan_curve_pwm_interpolator.sv
`timescale 1ns / 100ps
// testbench top: drives temperature samples, curve writes and duty back-pressure
module tb_fan_curve_pwm_interpolator;
  import fcpi_pkg::*;
  import fcpi_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 125;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 48;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_EVERY3} ready_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic                  pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;

  int fail_cnt, due_cnt, checked_cnt, above_cnt, writes_cnt;
  int cycle_cnt;
  int hold_req;
  int burst_left;
  int settings_cnt;

  fcpi_temp_if temp_ch();
  fcpi_duty_if duty_ch();

  fan_curve_pwm_interpolator DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(temp_ch),
    .duty_o  (duty_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fcpi_duty_check u_duty_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .temp_w       (temp_ch),
    .duty_w       (duty_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_cnt_o   (fail_cnt),
    .due_cnt_o    (due_cnt),
    .checked_cnt_o(checked_cnt),
    .above_cnt_o  (above_cnt),
    .writes_cnt_o (writes_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("run stopped after %0d cycles with %0d duty results outstanding",
             cycle_cnt, due_cnt);
    $display("FAILED: results differ");
    $finish;
  end

  // duty side back-pressure, with a long hold-off whenever one is requested
  initial begin : ready_gen
    ready_mode_e mode;
    int          left, hold_left, hold_done;
    duty_ch.ready = 1'b0;
    mode          = RDY_ALWAYS;
    left          = 0;
    hold_left     = 0;
    hold_done     = 0;
    forever begin
      @(posedge clk_i);
      if (hold_done != hold_req) begin
        hold_done = hold_req;
        hold_left = LONG_HOLD;
      end
      if (left == 0) begin
        mode = ready_mode_e'($urandom_range(RDY_ALWAYS, RDY_EVERY3));
        left = $urandom_range(20, 200);
      end
      left--;
      if (hold_left > 0) begin
        hold_left--;
        duty_ch.ready <= 1'b0;
      end else begin
        case (mode)
          RDY_ALWAYS: duty_ch.ready <= 1'b1;
          RDY_COIN:   duty_ch.ready <= ($urandom_range(0, 1) == 1);
          RDY_SPARSE: duty_ch.ready <= ($urandom_range(0, 3) == 0);
          default:    duty_ch.ready <= (left % 3 == 0);
        endcase
      end
    end
  end

  // setup, access, then an idle gap so back-to-back writes stay apart
  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // drop valid and wait until every predicted duty has been taken
  task automatic wait_idle();
    temp_ch.valid <= 1'b0;
    do @(posedge clk_i); while (due_cnt != 0);
  endtask

  task automatic apply_curve(input logic [31:0] temps, input logic [31:0] pcts,
                             input logic [2:0] cnt);
    wait_idle();
    apb_write(CURVE_TEMPS_ADDR, temps);
    apb_write(CURVE_PCTS_ADDR, pcts);
    apb_write(POINT_COUNT_ADDR, {29'd0, cnt});
    settings_cnt++;
  endtask

  // valid stays high across a burst; a gap lowers it for a random stretch
  task automatic offer_sample(input logic signed [TEMP_W-1:0] val);
    int gap;
    temp_ch.valid      <= 1'b1;
    temp_ch.temp_milli <= val;
    do @(posedge clk_i); while (!temp_ch.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left    = $urandom_range(0, 24);
      gap           = $urandom_range(1, 40);
      temp_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic offer_list(input int vals[$]);
    foreach (vals[i]) offer_sample(TEMP_W'(vals[i]));
  endtask

  task automatic pick_curve(output logic [31:0] temps, output logic [31:0] pcts,
                            output logic [2:0] cnt);
    int shape, deg;
    shape = $urandom_range(0, 9);
    deg   = $urandom_range(0, 40);
    temps = '0;
    pcts  = '0;
    // ascending curve by default; a zero step gives a flat segment
    for (int b = 0; b < 4; b++) begin
      temps[8*b +: 8] = 8'(deg);
      pcts[8*b +: 8]  = 8'($urandom_range(0, 100));
      deg += $urandom_range(0, 30);
    end
    cnt = 3'($urandom_range(2, 4));
    case (shape)
      6: begin
        temps = $urandom;
        pcts  = $urandom;
        cnt   = 3'($urandom_range(0, 7));
      end
      7: temps = {temps[7:0], temps[15:8], temps[23:16], temps[31:24]};
      8: pcts = $urandom;
      9: begin
        temps = ($urandom_range(0, 1) == 1) ? '1 : '0;
        pcts  = ($urandom_range(0, 1) == 1) ? '1 : '0;
        cnt   = 3'($urandom_range(0, 7));
      end
      default: ;
    endcase
  endtask

  function automatic logic signed [TEMP_W-1:0] pick_sample(input logic [31:0] temps);
    int          sel, k, v;
    logic [31:0] raw;
    sel = $urandom_range(0, 9);
    k   = $urandom_range(0, 3);
    raw = $urandom;
    if (sel < 4) begin
      v = int'(temps[8*k +: 8]) * 1000 + $urandom_range(0, 2) - 1;
    end else if (sel < 8) begin
      v = $urandom_range(0, 145000) - 5000;
    end else begin
      return raw[TEMP_W-1:0];
    end
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return TEMP_W'(v);
  endfunction

  initial begin : stimulus
    logic [31:0] t_cfg, p_cfg;
    logic [2:0]  n_cfg;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    temp_ch.valid      = 1'b0;
    temp_ch.temp_milli = '0;
    hold_req           = 0;
    burst_left         = 0;
    settings_cnt       = 1;
    rst_ni             = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset curve: both points at zero degrees, so one flat segment
    offer_list('{0, -131072, 131071, 1});

    // ordinary ascending curve: extrapolation, breakpoints, above the curve
    apply_curve(32'h5A46_321E, 32'h6446_2814, 3'd4);
    offer_list('{-131072, -1, 0, 29999, 30000, 45678, 50000, 50001, 90000, 90001,
                 131071});

    // descending temperatures with percents far above 100
    apply_curve(32'h0A1E_3250, 32'hFFFF_FFFF, 3'd3);
    offer_list('{20000, 60000, -5000});

    // point count above range, every breakpoint equal
    apply_curve(32'h8080_8080, 32'h0064_3200, 3'd7);
    offer_list('{128000, 127999, 128001});

    // point count below range, all-ones temperatures
    apply_curve(32'hFFFF_FFFF, 32'h0000_0000, 3'd0);
    offer_list('{131071, -131072});

    for (int ph = 0; ph < PHASES; ph++) begin
      pick_curve(t_cfg, p_cfg, n_cfg);
      apply_curve(t_cfg, p_cfg, n_cfg);
      // long receiver hold-off while samples keep coming
      if (ph == 2) hold_req++;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 5 && k == PHASE_ITEMS / 2) wait_idle();
        offer_sample(pick_sample(t_cfg));
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("checked %0d duty transactions over %0d curve settings",
             checked_cnt, settings_cnt);
    $display("%0d new duties flagged for writing, %0d samples above the curve",
             writes_cnt, above_cnt);
    if (fail_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
